FILE: rtl/core/tcf_pkg.sv
`default_nettype none
package tcf_pkg;

	// segment summary as it arrives
	typedef struct packed {
		logic [31:0] remote_address;
		logic [15:0] peer_port;
		logic [15:0] host_port;
		logic [5:0]  segment_flags;
		logic [31:0] segment_sequence;
		logic        checksum_good;
	} in_beat_t;

	// result of one segment
	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  entry_index;
		logic [5:0]  reply_flags;
		logic [31:0] reply_sequence;
		logic [31:0] reply_acknowledge;
		logic [15:0] reply_source_port;
		logic [15:0] reply_destination_port;
	} out_beat_t;

	// classified segment held in the queue between front and back
	typedef struct packed {
		logic [31:0] remote_address;
		logic [15:0] peer_port;
		logic [15:0] host_port;
		logic [31:0] segment_sequence;
		logic        good;
		logic        syn;
		logic        ack;
		logic        fin;
	} seg_cmd_t;

	typedef enum logic [1:0] {
		COND_LISTEN      = 2'd0,
		COND_SYN_RECVD   = 2'd1,
		COND_ESTABLISHED = 2'd2,
		COND_LAST_ACK    = 2'd3
	} cond_t;

	localparam logic [1:0] ACT_DROP    = 2'd0;
	localparam logic [1:0] ACT_QUIET   = 2'd1;
	localparam logic [1:0] ACT_REPLY   = 2'd2;
	localparam logic [1:0] ACT_DELIVER = 2'd3;

	localparam logic [5:0] FLAG_FIN = 6'h01;
	localparam logic [5:0] FLAG_SYN = 6'h02;
	localparam logic [5:0] FLAG_ACK = 6'h10;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);

endpackage
`default_nettype wire

FILE: rtl/core/tcf_front.sv
`default_nettype none
module tcf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seg_valid,
	output logic                   seg_stall,
	input  wire tcf_pkg::in_beat_t seg,
	input  wire logic              q_full,
	output logic                   q_push,
	output tcf_pkg::seg_cmd_t      q_wdata
);
	import tcf_pkg::*;

	logic     valid_s1;
	seg_cmd_t cmd_s1;
	logic     accept;

	assign seg_stall = valid_s1 & q_full;
	assign accept    = seg_valid & ~seg_stall;
	assign q_push    = valid_s1 & ~q_full;
	assign q_wdata   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// flag decode happens here so the back end sees one bit per test
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.remote_address   <= seg.remote_address;
			cmd_s1.peer_port        <= seg.peer_port;
			cmd_s1.host_port        <= seg.host_port;
			cmd_s1.segment_sequence <= seg.segment_sequence;
			cmd_s1.good             <= seg.checksum_good;
			cmd_s1.syn              <= |(seg.segment_flags & FLAG_SYN);
			cmd_s1.ack              <= |(seg.segment_flags & FLAG_ACK);
			cmd_s1.fin              <= |(seg.segment_flags & FLAG_FIN);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/tcf_queue.sv
`default_nettype none
module tcf_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tcf_pkg::seg_cmd_t wdata,
	input  wire logic              pop,
	output tcf_pkg::seg_cmd_t      rdata,
	output logic                   full,
	output logic                   empty
);
	import tcf_pkg::*;

	seg_cmd_t         slot_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (QPW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/tcf_back.sv
`default_nettype none
module tcf_back #(
	parameter int CONNECTIONS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [31:0]       cfg_wr_data,
	input  wire logic              q_empty,
	input  wire tcf_pkg::seg_cmd_t q_rdata,
	output logic                   q_pop,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output tcf_pkg::out_beat_t     res
);
	import tcf_pkg::*;

	localparam int IDXW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PICK,
		ST_EXEC
	} bstate_t;

	bstate_t         state_q;
	seg_cmd_t        cmd_q;
	logic [31:0]     init_seq_q;
	logic [CONNECTIONS-1:0] match_q;
	logic [CONNECTIONS-1:0] listen_q;
	logic [IDXW-1:0] slot_q;
	logic            found_q;
	logic            have_q;
	logic            res_valid_q;
	out_beat_t       res_q;

	logic [31:0] ent_addr_q  [CONNECTIONS];
	logic [15:0] ent_rport_q [CONNECTIONS];
	logic [15:0] ent_lport_q [CONNECTIONS];
	cond_t       ent_cond_q  [CONNECTIONS];
	logic [31:0] ent_lseq_q  [CONNECTIONS];
	logic [31:0] ent_rseq_q  [CONNECTIONS];

	logic [CONNECTIONS-1:0] match_vec;
	logic [CONNECTIONS-1:0] listen_vec;
	logic            sel_found;
	logic            sel_have;
	logic [IDXW-1:0] sel_match;
	logic [IDXW-1:0] sel_listen;
	logic            fire;

	logic        wr;
	logic [31:0] n_addr;
	logic [15:0] n_rport;
	logic [15:0] n_lport;
	cond_t       n_cond;
	logic [31:0] n_lseq;
	logic [31:0] n_rseq;
	out_beat_t   r;
	cond_t       cur_cond;
	logic [31:0] cur_lseq;
	logic [31:0] cur_rseq;

	assign q_pop     = (state_q == ST_IDLE) & ~q_empty;
	assign fire      = (state_q == ST_EXEC) & (~res_valid_q | ~res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_seq_q <= '0;
		end else if (cfg_wr_en) begin
			init_seq_q <= cfg_wr_data;
		end
	end

	// all entries compared at once
	always_comb begin
		for (int k = 0; k < CONNECTIONS; k++) begin
			match_vec[k]  = (ent_addr_q[k] == cmd_q.remote_address) &&
				(ent_rport_q[k] == cmd_q.peer_port) &&
				(ent_lport_q[k] == cmd_q.host_port);
			listen_vec[k] = (ent_cond_q[k] == COND_LISTEN);
		end
	end

	// lowest match wins; highest free entry is taken otherwise
	always_comb begin
		sel_found  = 1'b0;
		sel_match  = '0;
		sel_have   = 1'b0;
		sel_listen = '0;
		for (int k = CONNECTIONS-1; k >= 0; k--) begin
			if (match_q[k]) begin
				sel_found = 1'b1;
				sel_match = IDXW'(k);
			end
		end
		for (int k = 0; k < CONNECTIONS; k++) begin
			if (listen_q[k]) begin
				sel_have   = 1'b1;
				sel_listen = IDXW'(k);
			end
		end
	end

	assign cur_cond = ent_cond_q[slot_q];
	assign cur_lseq = ent_lseq_q[slot_q];
	assign cur_rseq = ent_rseq_q[slot_q];

	always_comb begin
		r       = '0;
		r.action = ACT_DROP;
		wr      = 1'b0;
		n_addr  = cmd_q.remote_address;
		n_rport = cmd_q.peer_port;
		n_lport = cmd_q.host_port;
		n_cond  = cur_cond;
		n_lseq  = cur_lseq;
		n_rseq  = cur_rseq;
		if (cmd_q.good && (found_q || have_q)) begin
			wr            = 1'b1;
			r.action      = ACT_QUIET;
			r.entry_index = 2'(slot_q);
			unique case (cur_cond)
				COND_LISTEN: begin
					if (cmd_q.syn) begin
						n_cond                   = COND_SYN_RECVD;
						n_lseq                   = init_seq_q + 32'd1;
						n_rseq                   = cmd_q.segment_sequence;
						r.action                 = ACT_REPLY;
						r.reply_flags            = FLAG_SYN | FLAG_ACK;
						r.reply_sequence         = init_seq_q;
						r.reply_acknowledge      = cmd_q.segment_sequence;
						r.reply_source_port      = cmd_q.host_port;
						r.reply_destination_port = cmd_q.peer_port;
					end
				end
				COND_SYN_RECVD: begin
					if (cmd_q.ack) begin
						n_rseq = cmd_q.segment_sequence;
						n_cond = COND_ESTABLISHED;
					end
				end
				COND_ESTABLISHED: begin
					if (cmd_q.fin) begin
						n_cond                   = COND_LAST_ACK;
						n_lseq                   = cur_lseq + 32'd1;
						r.action                 = ACT_REPLY;
						r.reply_flags            = FLAG_FIN | FLAG_ACK;
						r.reply_sequence         = cur_lseq;
						r.reply_acknowledge      = cur_rseq;
						r.reply_source_port      = cmd_q.host_port;
						r.reply_destination_port = cmd_q.peer_port;
					end else begin
						r.action = ACT_DELIVER;
					end
				end
				COND_LAST_ACK: begin
					if (cmd_q.ack) begin
						n_addr  = '0;
						n_rport = '0;
						n_lport = '0;
						n_cond  = COND_LISTEN;
						n_lseq  = '0;
						n_rseq  = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			cmd_q       <= '0;
			match_q     <= '0;
			listen_q    <= '0;
			found_q     <= 1'b0;
			have_q      <= 1'b0;
			slot_q      <= '0;
			res_q       <= '0;
		end else begin
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q   <= q_rdata;
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					match_q  <= match_vec;
					listen_q <= listen_vec;
					state_q  <= ST_PICK;
				end
				ST_PICK: begin
					found_q <= sel_found;
					have_q  <= sel_have;
					slot_q  <= sel_found ? sel_match : sel_listen;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						res_q   <= r;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CONNECTIONS; k++) begin
				ent_addr_q[k]  <= '0;
				ent_rport_q[k] <= '0;
				ent_lport_q[k] <= '0;
				ent_cond_q[k]  <= COND_LISTEN;
				ent_lseq_q[k]  <= '0;
				ent_rseq_q[k]  <= '0;
			end
		end else if (fire && wr) begin
			ent_addr_q[slot_q]  <= n_addr;
			ent_rport_q[slot_q] <= n_rport;
			ent_lport_q[slot_q] <= n_lport;
			ent_cond_q[slot_q]  <= n_cond;
			ent_lseq_q[slot_q]  <= n_lseq;
			ent_rseq_q[slot_q]  <= n_rseq;
		end
	end

`ifndef SYNTHESIS
	a_exec_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q)
		else $error("result beat missing after execute");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_MATCH))
		else $error("pop did not start a lookup");
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action == ACT_DROP) |->
		(res_q.entry_index == 2'd0 && res_q.reply_flags == 6'd0))
		else $error("dropped beat carries entry or reply data");
	a_reply_has_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action == ACT_REPLY) |-> |(res_q.reply_flags & FLAG_ACK))
		else $error("reply without ACK bit");
	a_noreply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action != ACT_REPLY) |->
		(res_q.reply_sequence == 32'd0 && res_q.reply_acknowledge == 32'd0))
		else $error("reply fields set on non-reply beat");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/tcp_connection_table_fsm.sv
// A segment beat is registered in the front stage and queued; the back-end sequencer then takes it
// through dequeue, parallel compare, entry select, execute and update, one segment at a time,
// dequeuing the next only after the last one's result is registered.
// A two-entry queue lets the front take segments while the back is busy or stalled.
// Reset (arst_n low, asynchronous): all entries in LISTEN with zero fields,
// initial sequence zero, queue empty, no result pending.
`default_nettype none
module tcp_connection_table_fsm #(
	parameter int CONNECTIONS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seg_valid,
	output logic                    seg_stall,
	input  wire tcf_pkg::in_beat_t  seg,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output tcf_pkg::out_beat_t      res,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data
);
	import tcf_pkg::*;

	logic     q_full;
	logic     q_empty;
	logic     q_push;
	logic     q_pop;
	seg_cmd_t q_wdata;
	seg_cmd_t q_rdata;

	tcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	tcf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	tcf_back #(
		.CONNECTIONS (CONNECTIONS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule
`default_nettype wire

FILE: bench/tcp_connection_table_fsm_test.sv
module tcp_connection_table_fsm_test;
	import tcf_pkg::*;

	localparam int CONNS = 4;
	localparam int POOL = 6;
	localparam int HOLD_CYCLES = 80;
	localparam logic [5:0] FLAG_RST = 6'h04;
	localparam logic [5:0] FLAG_PSH = 6'h08;
	localparam logic [5:0] FLAG_URG = 6'h20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	in_beat_t seg = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_beat_t res;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	tcp_connection_table_fsm #(
		.CONNECTIONS(CONNS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// connection table as the block should hold it
	logic [31:0] conn_addr [CONNS];
	logic [15:0] conn_rport [CONNS];
	logic [15:0] conn_lport [CONNS];
	cond_t conn_cond [CONNS];
	logic [31:0] conn_lseq [CONNS];
	logic [31:0] conn_rseq [CONNS];
	logic [31:0] isn_setting = '0;

	out_beat_t pending_results [$];

	logic [31:0] pool_addr [POOL];
	logic [15:0] pool_rport [POOL];
	logic [15:0] pool_lport [POOL];

	bit idle_on = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int stall_left = 0;

	int mismatches = 0;
	int segments_sent = 0;
	int results_seen = 0;
	int replies_seen = 0;
	int deliveries_seen = 0;
	int drops_seen = 0;
	int isn_writes = 0;

	function automatic void clear_conn(int k);
		conn_addr[k] = '0;
		conn_rport[k] = '0;
		conn_lport[k] = '0;
		conn_cond[k] = COND_LISTEN;
		conn_lseq[k] = '0;
		conn_rseq[k] = '0;
	endfunction

	// lowest entry holding this tuple, -1 if none
	function automatic int find_conn(logic [31:0] a, logic [15:0] rp, logic [15:0] lp);
		int k;
		int hit;
		hit = -1;
		for (k = CONNS - 1; k >= 0; k--)
			if (conn_addr[k] == a && conn_rport[k] == rp && conn_lport[k] == lp)
				hit = k;
		return hit;
	endfunction

	// reply header; the entry's local sequence advances past it
	function automatic out_beat_t reply_from(int k, logic [5:0] flags);
		out_beat_t r;
		r = '0;
		r.action = ACT_REPLY;
		r.entry_index = k[1:0];
		r.reply_flags = flags;
		r.reply_sequence = conn_lseq[k];
		r.reply_acknowledge = conn_rseq[k];
		r.reply_source_port = conn_lport[k];
		r.reply_destination_port = conn_rport[k];
		conn_lseq[k] = conn_lseq[k] + 32'd1;
		return r;
	endfunction

	function automatic out_beat_t predict_segment(in_beat_t s);
		out_beat_t r;
		int slot;
		int k;
		r = '0;
		r.action = ACT_DROP;
		if (!s.checksum_good)
			return r;
		slot = find_conn(s.remote_address, s.peer_port, s.host_port);
		if (slot < 0) begin
			// no match: highest free entry takes the tuple
			for (k = 0; k < CONNS; k++)
				if (conn_cond[k] == COND_LISTEN)
					slot = k;
			if (slot < 0)
				return r;
			conn_addr[slot] = s.remote_address;
			conn_rport[slot] = s.peer_port;
			conn_lport[slot] = s.host_port;
		end
		r.action = ACT_QUIET;
		r.entry_index = slot[1:0];
		case (conn_cond[slot])
			COND_LISTEN: begin
				if ((s.segment_flags & FLAG_SYN) != 0) begin
					conn_cond[slot] = COND_SYN_RECVD;
					conn_lseq[slot] = isn_setting;
					conn_rseq[slot] = s.segment_sequence;
					r = reply_from(slot, FLAG_SYN | FLAG_ACK);
				end
			end
			COND_SYN_RECVD: begin
				if ((s.segment_flags & FLAG_ACK) != 0) begin
					conn_rseq[slot] = s.segment_sequence;
					conn_cond[slot] = COND_ESTABLISHED;
				end
			end
			COND_ESTABLISHED: begin
				if ((s.segment_flags & FLAG_FIN) != 0) begin
					conn_cond[slot] = COND_LAST_ACK;
					r = reply_from(slot, FLAG_FIN | FLAG_ACK);
				end else begin
					r.action = ACT_DELIVER;
				end
			end
			default: begin
				if ((s.segment_flags & FLAG_ACK) != 0)
					clear_conn(slot);
			end
		endcase
		return r;
	endfunction

	function automatic in_beat_t segment_of(logic [31:0] a, logic [15:0] rp, logic [15:0] lp,
			logic [5:0] flags, logic [31:0] sq, logic good);
		in_beat_t s;
		s.remote_address = a;
		s.peer_port = rp;
		s.host_port = lp;
		s.segment_flags = flags;
		s.segment_sequence = sq;
		s.checksum_good = good;
		return s;
	endfunction

	// mostly pooled tuples with the flag their entry needs next
	function automatic in_beat_t random_segment();
		in_beat_t s;
		int p;
		int slot;
		cond_t st;
		logic [5:0] noise;
		noise = 6'($urandom_range(0, 63));
		s = segment_of($urandom, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), noise, $urandom, $urandom_range(0, 9) != 0);
		if ($urandom_range(0, 19) != 0) begin
			p = $urandom_range(0, POOL - 1);
			s.remote_address = pool_addr[p];
			s.peer_port = pool_rport[p];
			s.host_port = pool_lport[p];
			if ($urandom_range(0, 3) != 0) begin
				slot = find_conn(s.remote_address, s.peer_port, s.host_port);
				st = (slot < 0) ? COND_LISTEN : conn_cond[slot];
				case (st)
					COND_LISTEN: s.segment_flags = noise | FLAG_SYN;
					COND_ESTABLISHED: begin
						if ($urandom_range(0, 3) == 0)
							s.segment_flags = noise | FLAG_FIN;
						else
							s.segment_flags = noise & ~FLAG_FIN;
					end
					default: s.segment_flags = noise | FLAG_ACK;
				endcase
			end
		end
		return s;
	endfunction

	task automatic report_mismatch(string why, out_beat_t want, out_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s) at %0t", why, $realtime);
			$display("  expected act=%0d idx=%0d fl=%h sq=%h ak=%h sp=%h dp=%h",
				want.action, want.entry_index, want.reply_flags, want.reply_sequence,
				want.reply_acknowledge, want.reply_source_port, want.reply_destination_port);
			$display("  got      act=%0d idx=%0d fl=%h sq=%h ak=%h sp=%h dp=%h",
				got.action, got.entry_index, got.reply_flags, got.reply_sequence,
				got.reply_acknowledge, got.reply_source_port, got.reply_destination_port);
		end
	endtask

	task automatic check_result(out_beat_t got);
		out_beat_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			want = 'x;
			report_mismatch("no result expected", want, got);
		end else begin
			want = pending_results.pop_front();
			case (want.action)
				ACT_REPLY: replies_seen++;
				ACT_DELIVER: deliveries_seen++;
				ACT_DROP: drops_seen++;
				default: ;
			endcase
			if (got.action !== want.action || got.entry_index !== want.entry_index ||
					got.reply_flags !== want.reply_flags ||
					got.reply_sequence !== want.reply_sequence ||
					got.reply_acknowledge !== want.reply_acknowledge ||
					got.reply_source_port !== want.reply_source_port ||
					got.reply_destination_port !== want.reply_destination_port)
				report_mismatch("field differs", want, got);
		end
	endtask

	// result side: check each beat, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_result(res);
		if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			stall_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// called at a rising edge; returns at the edge that took the beat
	task automatic offer_segment(in_beat_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			seg_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		seg <= s;
		seg_valid <= 1'b1;
		do
			@(posedge clk);
		while (seg_stall);
		pending_results.push_back(predict_segment(s));
		segments_sent++;
	endtask

	task automatic wait_drained();
		seg_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_initial_sequence(logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		isn_setting = v;
		isn_writes++;
	endtask

	task automatic refill_pool();
		int p;
		for (p = 0; p < POOL; p++) begin
			pool_addr[p] = $urandom;
			pool_rport[p] = 16'($urandom_range(0, 65535));
			pool_lport[p] = 16'($urandom_range(0, 65535));
		end
		// the all-zero tuple matches untouched entries
		pool_addr[0] = '0;
		pool_rport[0] = '0;
		pool_lport[0] = '0;
		pool_addr[1] = '1;
		pool_rport[1] = '1;
		pool_lport[1] = '1;
	endtask

	task automatic test_directed();
		int i;
		set_initial_sequence(32'hFFFF_FFFF);
		idle_on = 1'b1;
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80, FLAG_SYN, 32'h1111, 1'b0));
		// all flags at once: only SYN counts in LISTEN
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80,
			FLAG_URG | FLAG_ACK | FLAG_PSH | FLAG_RST | FLAG_SYN | FLAG_FIN,
			32'hFFFF_FFFF, 1'b1));
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80, FLAG_ACK, 32'h0, 1'b1));
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80,
			FLAG_PSH | FLAG_URG | FLAG_RST, 32'h5, 1'b1));
		// the FIN reply carries the local sequence that wrapped to zero at the SYN
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80, FLAG_FIN, 32'h6, 1'b1));
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80, FLAG_SYN, 32'h7, 1'b1));
		offer_segment(segment_of(32'hC0A8_0001, 16'd1234, 16'd80, FLAG_ACK, 32'h8, 1'b1));
		offer_segment(segment_of(32'h0, 16'h0, 16'h0, FLAG_ACK, 32'h0, 1'b1));
		offer_segment(segment_of('1, '1, '1, 6'h00, '1, 1'b1));
		// fill every entry, then one more opens nothing
		for (i = 0; i < 5; i++)
			offer_segment(segment_of(32'h0A00_0010 + i, 16'(16'd4000 + i), 16'd443, FLAG_SYN,
				32'hABCD_0000 + i, 1'b1));
		for (i = 0; i < 4; i++) begin
			offer_segment(segment_of(32'h0A00_0010 + i, 16'(16'd4000 + i), 16'd443, FLAG_ACK,
				32'h8000_0000 + i, 1'b1));
			offer_segment(segment_of(32'h0A00_0010 + i, 16'(16'd4000 + i), 16'd443, FLAG_FIN,
				32'h0, 1'b1));
			offer_segment(segment_of(32'h0A00_0010 + i, 16'(16'd4000 + i), 16'd443, FLAG_ACK,
				32'h0, 1'b1));
		end
	endtask

	task automatic test_random_traffic(int count, bit allow_idle);
		int n;
		refill_pool();
		for (n = 0; n < count; n++) begin
			if (n % 50 == 0)
				idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			offer_segment(random_segment());
		end
	endtask

	// receiver holds off while segments keep coming, so the input stalls
	task automatic test_backpressure();
		int n;
		idle_on = 1'b0;
		hold_requests <= hold_requests + 1;
		for (n = 0; n < 12; n++)
			offer_segment(random_segment());
	endtask

	initial begin
		int k;
		for (k = 0; k < CONNS; k++)
			clear_conn(k);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		set_initial_sequence(32'h0);
		test_random_traffic(350, 1'b1);
		wait_drained();
		set_initial_sequence($urandom);
		test_backpressure();
		test_random_traffic(350, 1'b1);
		wait_drained();
		set_initial_sequence(32'h8000_0000);
		test_random_traffic(300, 1'b0);
		wait_drained();

		$display("%0d segments in, %0d results checked: %0d replies, %0d deliveries, %0d drops",
			segments_sent, results_seen, replies_seen, deliveries_seen, drops_seen);
		$display("initial sequence set %0d times, %0d mismatches", isn_writes, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tcf_pkg.sv
rtl/core/tcf_front.sv
rtl/core/tcf_queue.sv
rtl/core/tcf_back.sv
rtl/core/tcp_connection_table_fsm.sv
bench/tcp_connection_table_fsm_test.sv
